[hw/rtl/tsfc_pkg.sv]
// Package for the thermal sensor fuse calibration block.
// Holds widths, status and register codes, correction tables and the stage structs.
// No dependencies.
package tsfc_pkg;

    localparam int SENSOR_SLOTS = 8;
    localparam int SENSORS_SMALL = 6;
    localparam int IDX_W = 3;
    localparam int FUSE_W = 26;
    localparam int WORD_W = 32;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_CHIP_VARIANT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHARED_FUSE = 1'd1;

    localparam logic [1:0] STATUS_OK = 2'd0;
    localparam logic [1:0] STATUS_RANGE = 2'd1;
    localparam logic [1:0] STATUS_ZERO = 2'd2;

    localparam int NUM_W = 25;
    localparam int DEN_W = 17;
    localparam int Q_W = 16;
    localparam int DIV_STEPS = 5;
    localparam int DIV_STAGES = NUM_W / DIV_STEPS;

    localparam int ALPHA_W = 22;
    localparam int BETA_W = 24;

    // 2^44 / 15625 rounded up; exact for dividends below 2^30.
    localparam logic [30:0] RECIP_15625 = 31'd1125899907;

    localparam logic signed [ALPHA_W-1:0] ALPHA_TBL [SENSOR_SLOTS] = '{
        22'sd1085000, 22'sd1126200, 22'sd1098400, 22'sd1108000,
        22'sd1069200, 22'sd1173700, 22'sd1074300, 22'sd1039700};
    localparam logic signed [BETA_W-1:0] BETA_TBL [SENSOR_SLOTS] = '{
        24'sd3244200, -24'sd67500, 24'sd2251100, 24'sd602700,
        24'sd3549900, -24'sd6263600, 24'sd2734900, 24'sd6829100};

    typedef struct packed {
        logic [1:0]                 status;
        logic signed [ALPHA_W-1:0]  alpha;
        logic signed [BETA_W-1:0]   beta;
        logic                       neg_a;
        logic                       neg_b;
    } tag_t;

    typedef struct packed {
        logic               valid;
        tag_t               tag;
        logic [NUM_W-1:0]   num_a;
        logic [NUM_W-1:0]   num_b;
        logic [DEN_W-1:0]   den;
    } div_in_t;

    typedef struct packed {
        logic           valid;
        tag_t           tag;
        logic [Q_W-1:0] qa;
        logic [Q_W-1:0] qb;
    } div_out_t;

    // The six-sensor part drops the two memory sensors in table slots four and five.
    function automatic logic [IDX_W-1:0] table_slot(input logic variant,
                                                    input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] slot;
        slot = idx;
        if (variant && idx >= IDX_W'(4))
        begin
            slot = idx + IDX_W'(2);
        end
        return slot;
    endfunction

endpackage

[hw/rtl/tsfc_if.sv]
// Channel interfaces of the thermal sensor fuse calibration block.
// Depends on tsfc_pkg for field widths.
interface tsfc_in_if;
    logic                           valid;
    logic                           ready;
    logic [tsfc_pkg::IDX_W-1:0]     sensor_index;
    logic [tsfc_pkg::FUSE_W-1:0]    sensor_fuse;
    modport source (output valid, output sensor_index, output sensor_fuse, input ready);
    modport sink (input valid, input sensor_index, input sensor_fuse, output ready);
endinterface

interface tsfc_out_if;
    logic                           valid;
    logic                           ready;
    logic [tsfc_pkg::WORD_W-1:0]    calib_word;
    logic [1:0]                     status;
    modport source (output valid, output calib_word, output status, input ready);
    modport sink (input valid, input calib_word, input status, output ready);
endinterface

interface tsfc_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [tsfc_pkg::CFG_IDX_W-1:0]     index;
    logic [tsfc_pkg::WORD_W-1:0]        data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[hw/rtl/tsfc_front.sv]
// Front stages: fuse field decode, base codes, products and divider operands.
// Depends on tsfc_pkg.
module tsfc_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic [tsfc_pkg::IDX_W-1:0]      sensor_index,
    input  logic [tsfc_pkg::FUSE_W-1:0]     sensor_fuse,
    input  logic                            chip_variant,
    input  logic [tsfc_pkg::WORD_W-1:0]     shared_fuse_word,
    output tsfc_pkg::div_in_t               dout
);
    import tsfc_pkg::*;

    // Stage one registers.
    logic                       v1_reg;
    logic [1:0]                 st1_reg, st1_next;
    logic signed [ALPHA_W-1:0]  alpha1_reg, alpha1_next;
    logic signed [BETA_W-1:0]   beta1_reg, beta1_next;
    logic signed [17:0]         act_ft_reg, act_ft_next, act_cp_reg, act_cp_next;
    logic signed [8:0]          temp_ft_reg, temp_ft_next, temp_cp_reg, temp_cp_next;
    // Stage two registers.
    logic                       v2_reg;
    logic [1:0]                 st2_reg, st2_next;
    logic signed [ALPHA_W-1:0]  alpha2_reg;
    logic signed [BETA_W-1:0]   beta2_reg;
    logic signed [18:0]         dsens_reg, dsens_next;
    logic signed [8:0]          dtemp_reg, dtemp_next;
    logic signed [26:0]         p1_reg, p1_next, p2_reg, p2_next;
    // Stage three.
    div_in_t                    dout_reg, dout_next;

    logic [IDX_W-1:0]           slot;
    logic signed [27:0]         num_b;
    logic [27:0]                num_b_mag;
    logic [18:0]                dsens_mag;

    always_comb
    begin
        slot = table_slot(chip_variant, sensor_index);
        if (chip_variant)
            st1_next = (sensor_index >= IDX_W'(SENSORS_SMALL)) ? STATUS_RANGE : STATUS_OK;
        else
            st1_next = ({1'b0, sensor_index} >= (IDX_W+1)'(SENSOR_SLOTS)) ? STATUS_RANGE
                                                                       : STATUS_OK;
        alpha1_next = ALPHA_TBL[slot];
        beta1_next = BETA_TBL[slot];
        act_ft_next = $signed({1'b0, shared_fuse_word[31:21], 5'b0})
                    + $signed({{5{sensor_fuse[25]}}, sensor_fuse[25:13]});
        act_cp_next = $signed({1'b0, shared_fuse_word[20:11], 6'b0})
                    + $signed({{5{sensor_fuse[12]}}, sensor_fuse[12:0]});
        temp_ft_next = 9'sd210 + $signed({{4{shared_fuse_word[10]}}, shared_fuse_word[10:6]});
        temp_cp_next = 9'sd50 + $signed({{3{shared_fuse_word[5]}}, shared_fuse_word[5:0]});
    end

    always_comb
    begin
        dsens_next = 19'(act_ft_reg) - 19'(act_cp_reg);
        dtemp_next = temp_ft_reg - temp_cp_reg;
        p1_next = 27'(act_ft_reg) * 27'(temp_cp_reg);
        p2_next = 27'(act_cp_reg) * 27'(temp_ft_reg);
        st2_next = st1_reg;
        if (st1_reg == STATUS_OK && act_ft_reg == act_cp_reg)
        begin
            st2_next = STATUS_ZERO;
        end
    end

    always_comb
    begin
        num_b = 28'(p1_reg) - 28'(p2_reg);
        num_b_mag = num_b[27] ? 28'(-num_b) : 28'(num_b);
        dsens_mag = dsens_reg[18] ? 19'(-dsens_reg) : 19'(dsens_reg);
        dout_next.valid = v2_reg;
        dout_next.tag.status = st2_reg;
        dout_next.tag.alpha = alpha2_reg;
        dout_next.tag.beta = beta2_reg;
        dout_next.tag.neg_a = dsens_reg[18];
        dout_next.tag.neg_b = num_b[27] ^ dsens_reg[18];
        // The common factor of the two timing constants cancels: quotient is dtemp*32768/dsens.
        dout_next.num_a = NUM_W'({dtemp_reg[7:0], 15'b0});
        dout_next.num_b = num_b_mag[NUM_W-1:0];
        dout_next.den = dsens_mag[DEN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            dout_reg <= '0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            dout_reg <= dout_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st1_reg <= st1_next;
            alpha1_reg <= alpha1_next;
            beta1_reg <= beta1_next;
            act_ft_reg <= act_ft_next;
            act_cp_reg <= act_cp_next;
            temp_ft_reg <= temp_ft_next;
            temp_cp_reg <= temp_cp_next;
            st2_reg <= st2_next;
            alpha2_reg <= alpha1_reg;
            beta2_reg <= beta1_reg;
            dsens_reg <= dsens_next;
            dtemp_reg <= dtemp_next;
            p1_reg <= p1_next;
            p2_reg <= p2_next;
        end
    end

    assign dout = dout_reg;

endmodule

[hw/rtl/tsfc_div.sv]
// Pipelined restoring divider with two lanes sharing one divisor.
// Depends on tsfc_pkg.
module tsfc_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  tsfc_pkg::div_in_t   din,
    output tsfc_pkg::div_out_t  dout
);
    import tsfc_pkg::*;

    typedef struct packed {
        logic               valid;
        tag_t               tag;
        logic [NUM_W-1:0]   na;
        logic [NUM_W-1:0]   nb;
        logic [DEN_W:0]     ra;
        logic [DEN_W:0]     rb;
        logic [Q_W-1:0]     qa;
        logic [Q_W-1:0]     qb;
        logic [DEN_W-1:0]   den;
    } div_stage_t;

    // Only the low quotient bits are kept; the remainder chain still runs all steps.
    function automatic div_stage_t run_steps(input div_stage_t s);
        div_stage_t t;
        logic [DEN_W:0] ta;
        logic [DEN_W:0] tb;
        t = s;
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            ta = {t.ra[DEN_W-1:0], t.na[NUM_W-1]};
            tb = {t.rb[DEN_W-1:0], t.nb[NUM_W-1]};
            t.na = {t.na[NUM_W-2:0], 1'b0};
            t.nb = {t.nb[NUM_W-2:0], 1'b0};
            if (ta >= {1'b0, t.den})
            begin
                ta = ta - {1'b0, t.den};
                t.qa = {t.qa[Q_W-2:0], 1'b1};
            end
            else
            begin
                t.qa = {t.qa[Q_W-2:0], 1'b0};
            end
            if (tb >= {1'b0, t.den})
            begin
                tb = tb - {1'b0, t.den};
                t.qb = {t.qb[Q_W-2:0], 1'b1};
            end
            else
            begin
                t.qb = {t.qb[Q_W-2:0], 1'b0};
            end
            t.ra = ta;
            t.rb = tb;
        end
        return t;
    endfunction

    div_stage_t first;
    div_stage_t stage_reg [DIV_STAGES];
    div_stage_t stage_next [DIV_STAGES];

    always_comb
    begin
        first.valid = din.valid;
        first.tag = din.tag;
        first.na = din.num_a;
        first.nb = din.num_b;
        first.ra = '0;
        first.rb = '0;
        first.qa = '0;
        first.qb = '0;
        first.den = din.den;
        stage_next[0] = run_steps(first);
        for (int s = 1; s < DIV_STAGES; s++)
        begin
            stage_next[s] = run_steps(stage_reg[s-1]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < DIV_STAGES; s++)
            begin
                stage_reg[s] <= '0;
            end
        end
        else if (en)
        begin
            for (int s = 0; s < DIV_STAGES; s++)
            begin
                stage_reg[s] <= stage_next[s];
            end
        end
    end

    assign dout.valid = stage_reg[DIV_STAGES-1].valid;
    assign dout.tag = stage_reg[DIV_STAGES-1].tag;
    assign dout.qa = stage_reg[DIV_STAGES-1].qa;
    assign dout.qb = stage_reg[DIV_STAGES-1].qb;

endmodule

[hw/rtl/tsfc_scale.sv]
// Correction stages: alpha and beta scaling, division by one million, packing.
// Depends on tsfc_pkg.
module tsfc_scale (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  tsfc_pkg::div_out_t          din,
    output logic                        out_valid,
    output logic [tsfc_pkg::WORD_W-1:0] calib_word,
    output logic [1:0]                  status
);
    import tsfc_pkg::*;

    logic                   v1_reg, v2_reg, v3_reg, v4_reg;
    logic [1:0]             st1_reg, st2_reg, st3_reg, st4_reg;
    logic signed [BETA_W-1:0] beta1_reg;
    logic signed [37:0]     pa_reg, pa_next, pb_reg, pb_next;
    logic [29:0]            na_reg, na_next, nb_reg, nb_next;
    logic                   sa2_reg, sa2_next, sb2_reg, sb2_next, sa3_reg, sb3_reg;
    logic [60:0]            ma_reg, ma_next, mb_reg, mb_next;
    logic [WORD_W-1:0]      word_reg, word_next;

    logic signed [Q_W-1:0]  a_s, b_s;
    logic signed [37:0]     sum_b, mag_a, mag_b;
    logic [Q_W-1:0]         qa, qb;

    always_comb
    begin
        a_s = din.tag.neg_a ? $signed(Q_W'(-din.qa)) : $signed(din.qa);
        b_s = din.tag.neg_b ? $signed(Q_W'(-din.qb)) : $signed(din.qb);
        pa_next = 38'(a_s) * 38'(din.tag.alpha);
        pb_next = 38'(b_s) * 38'(din.tag.alpha);
    end

    // Division by 10^6 truncates toward zero: work on the magnitude, drop six bits,
    // then divide by 15625 through a reciprocal.
    always_comb
    begin
        sum_b = pb_reg + 38'(beta1_reg);
        sa2_next = pa_reg[37];
        sb2_next = sum_b[37];
        mag_a = pa_reg[37] ? -pa_reg : pa_reg;
        mag_b = sum_b[37] ? -sum_b : sum_b;
        na_next = mag_a[35:6];
        nb_next = mag_b[35:6];
        ma_next = 61'(na_reg) * 61'(RECIP_15625);
        mb_next = 61'(nb_reg) * 61'(RECIP_15625);
        qa = ma_reg[59:44];
        qb = mb_reg[59:44];
        word_next = '0;
        if (st3_reg == STATUS_OK)
        begin
            word_next[31:16] = sa3_reg ? Q_W'(-qa) : qa;
            word_next[15:0] = sb3_reg ? Q_W'(-qb) : qb;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= din.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st1_reg <= din.tag.status;
            beta1_reg <= din.tag.beta;
            pa_reg <= pa_next;
            pb_reg <= pb_next;
            st2_reg <= st1_reg;
            sa2_reg <= sa2_next;
            sb2_reg <= sb2_next;
            na_reg <= na_next;
            nb_reg <= nb_next;
            st3_reg <= st2_reg;
            sa3_reg <= sa2_reg;
            sb3_reg <= sb2_reg;
            ma_reg <= ma_next;
            mb_reg <= mb_next;
            st4_reg <= st3_reg;
            word_reg <= word_next;
        end
    end

    assign out_valid = v4_reg;
    assign calib_word = word_reg;
    assign status = st4_reg;

endmodule

[hw/rtl/thermal_sensor_fuse_calibration_core.sv]
// Top level of the thermal sensor fuse calibration block.
// Depends on tsfc_pkg, the tsfc channel interfaces, tsfc_front, tsfc_div and tsfc_scale.
//
// Usage:
//   in_ch carries one transaction per sensor: its table index and its fuse word.
//   out_ch returns one transaction for each input: the packed slope:offset
//   calibration word and a status code (ok, index out of range, zero delta).
//   cfg_ch writes the chip variant (index 0) and the shared fuse word (index 1);
//   it is always ready and should only be written while no item is in flight.
//   The datapath is a twelve-stage pipeline: three decode and product stages,
//   five divider stages of five quotient bits each, and four correction stages
//   with the last one being the output register. Throughput is one item per
//   cycle, limited by nothing but the output handshake.
//   When out_ch stalls with a valid result, the whole pipeline freezes and
//   in_ch.ready drops in the same cycle, so no transaction is lost or repeated.
//   Reset clears all valid bits and both configuration registers.
module thermal_sensor_fuse_calibration_core (
    input  logic        clk,
    input  logic        rst_n,
    tsfc_in_if.sink     in_ch,
    tsfc_out_if.source  out_ch,
    tsfc_cfg_if.sink    cfg_ch
);
    import tsfc_pkg::*;

    logic               chip_variant_reg;
    logic [WORD_W-1:0]  shared_fuse_reg;
    logic               en;
    logic               out_valid;
    div_in_t            front_out;
    div_out_t           div_out;

    // Global advance: the pipeline moves whenever the output stage can empty.
    assign en = !out_valid || out_ch.ready;
    assign in_ch.ready = en;
    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chip_variant_reg <= 1'b0;
            shared_fuse_reg <= '0;
        end
        else if (cfg_ch.valid)
        begin
            case (cfg_ch.index)
                REG_CHIP_VARIANT: chip_variant_reg <= cfg_ch.data[0];
                REG_SHARED_FUSE:  shared_fuse_reg <= cfg_ch.data;
                default:          ;
            endcase
        end
    end

    tsfc_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .en               (en),
        .in_valid         (in_ch.valid),
        .sensor_index     (in_ch.sensor_index),
        .sensor_fuse      (in_ch.sensor_fuse),
        .chip_variant     (chip_variant_reg),
        .shared_fuse_word (shared_fuse_reg),
        .dout             (front_out)
    );

    tsfc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .din   (front_out),
        .dout  (div_out)
    );

    tsfc_scale u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .din        (div_out),
        .out_valid  (out_valid),
        .calib_word (out_ch.calib_word),
        .status     (out_ch.status)
    );

    assign out_ch.valid = out_valid;

    // A flagged result never carries a calibration value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.status != STATUS_OK |-> out_ch.calib_word == '0)
        else $error("flagged result carries a nonzero calibration word");

    // A stalled output must hold off the input side.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |-> !in_ch.ready)
        else $error("input accepted while output stalled");

    // Status codes stay within the defined set.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> out_ch.status == STATUS_OK || out_ch.status == STATUS_RANGE
                         || out_ch.status == STATUS_ZERO)
        else $error("undefined status code");

endmodule
